FILE: rtl/core/asrtw_pkg.sv
// ---------------------------------------------------------------------------
// asrtw_pkg: shared types, command codes and GF(2^8) helpers
// Command codes, payload types and the byte arithmetic used by the AES
// S-box and round table word core.
// ---------------------------------------------------------------------------
package asrtw_pkg;

	typedef logic [2:0]  cmd_t;
	typedef logic [1:0]  row_t;
	typedef logic [7:0]  byte_t;
	typedef logic [31:0] word_t;

	// command codes
	localparam cmd_t CMD_SBOX     = 3'd0;
	localparam cmd_t CMD_INV_SBOX = 3'd1;
	localparam cmd_t CMD_FWD_TBL  = 3'd2;
	localparam cmd_t CMD_INV_TBL  = 3'd3;
	localparam cmd_t CMD_INV_MIX  = 3'd4;

	// field constants
	localparam byte_t GF_POLY     = 8'h1b;
	localparam byte_t AFF_FWD_C   = 8'h63;
	localparam byte_t AFF_INV_C   = 8'h05;

	// multiply by x, reduce by x^8+x^4+x^3+x+1
	function automatic byte_t xtime(input byte_t a);
		return {a[6:0], 1'b0} ^ (a[7] ? GF_POLY : 8'h00);
	endfunction

	// shift-and-add GF(2^8) product
	function automatic byte_t gf_mul(input byte_t p, input byte_t q);
		byte_t acc;
		byte_t a;
		acc = '0;
		a   = p;
		for (int k = 0; k < 8; k++) begin
			if (q[k]) begin
				acc = acc ^ a;
			end
			a = xtime(a);
		end
		return acc;
	endfunction

	function automatic byte_t gf_sq(input byte_t a);
		return gf_mul(a, a);
	endfunction

	// forward affine step applied after inversion
	function automatic byte_t aff_fwd(input byte_t t);
		return t ^ {t[6:0], t[7]} ^ {t[5:0], t[7:6]} ^ {t[4:0], t[7:5]}
			^ {t[3:0], t[7:4]} ^ AFF_FWD_C;
	endfunction

	// inverse affine step applied before inversion
	function automatic byte_t aff_inv(input byte_t s);
		return {s[6:0], s[7]} ^ {s[4:0], s[7:5]} ^ {s[1:0], s[7:2]} ^ AFF_INV_C;
	endfunction

endpackage

FILE: rtl/core/asrtw_req_if.sv
// ---------------------------------------------------------------------------
// asrtw_req_if: request channel
// Valid/ready channel carrying the command, the index byte and the row.
// ---------------------------------------------------------------------------
interface asrtw_req_if import asrtw_pkg::*; ();

	logic  valid;
	logic  ready;
	cmd_t  command;
	byte_t operand_byte;
	row_t  row_select;

	modport source (output valid, output command, output operand_byte,
		output row_select, input ready);
	modport sink (input valid, input command, input operand_byte,
		input row_select, output ready);

endinterface

FILE: rtl/core/asrtw_rsp_if.sv
// ---------------------------------------------------------------------------
// asrtw_rsp_if: response channel
// Valid/ready channel carrying one 32-bit table word.
// ---------------------------------------------------------------------------
interface asrtw_rsp_if import asrtw_pkg::*; ();

	logic  valid;
	logic  ready;
	word_t table_word;

	modport source (output valid, output table_word, input ready);
	modport sink (input valid, input table_word, output ready);

endinterface

FILE: rtl/core/aes_sbox_and_round_table_word_core.sv
// Throughput: one word per cycle when the output does not stall; the
// GF(2^8) inversion runs as an addition chain over four multiply stages.
// Each stage holds its item while the stage after it is full and stalled;
// empty stages fill even during an output stall.
// Reset clears the stage valid bits only; payload registers are not reset.
// ---------------------------------------------------------------------------
// aes_sbox_and_round_table_word_core: AES S-box and round table words
// Pipelined S-box, inverse S-box, forward/inverse round table and
// InvMixColumns column word generator.
// ---------------------------------------------------------------------------
module aes_sbox_and_round_table_word_core import asrtw_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	asrtw_req_if.sink        req,
	asrtw_rsp_if.source      rsp
);

	localparam int NUM_STAGES = 6;

	logic [NUM_STAGES:1]   vld;
	logic [NUM_STAGES+1:1] en;

	// stage payloads
	cmd_t  cmd_s1, cmd_s2, cmd_s3, cmd_s4, cmd_s5;
	row_t  row_s1, row_s2, row_s3, row_s4, row_s5;
	byte_t x_s1, x_s2, x_s3, x_s4, x_s5;
	byte_t a_s1, a_s2, a_s3;
	byte_t a3_s2, a7_s3, a7_s4, a15_s4, inv_s5;
	word_t word_s6;

	byte_t a_in;
	word_t word_nxt;

	// stall chain: a stage advances when empty or when its successor advances
	always_comb begin
		en[NUM_STAGES+1] = rsp.ready;
		for (int k = NUM_STAGES; k >= 1; k--) begin
			en[k] = !vld[k] || en[k+1];
		end
	end

	assign req.ready      = en[1];
	assign rsp.valid      = vld[NUM_STAGES];
	assign rsp.table_word = word_s6;

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else begin
			if (en[1]) begin
				vld[1] <= req.valid;
			end
			for (int k = 2; k <= NUM_STAGES; k++) begin
				if (en[k]) begin
					vld[k] <= vld[k-1];
				end
			end
		end
	end

	// pick the value to invert: undo the affine step for inverse lookups
	always_comb begin
		if (req.command == CMD_INV_SBOX || req.command == CMD_INV_TBL) begin
			a_in = aff_inv(req.operand_byte);
		end else begin
			a_in = req.operand_byte;
		end
	end

	// stage 1: capture request
	always_ff @(posedge clk) begin
		if (en[1]) begin
			cmd_s1 <= req.command;
			row_s1 <= req.row_select;
			x_s1   <= req.operand_byte;
			a_s1   <= a_in;
		end
	end

	// stage 2: a^3
	always_ff @(posedge clk) begin
		if (en[2]) begin
			cmd_s2 <= cmd_s1;
			row_s2 <= row_s1;
			x_s2   <= x_s1;
			a_s2   <= a_s1;
			a3_s2  <= gf_mul(gf_sq(a_s1), a_s1);
		end
	end

	// stage 3: a^7
	always_ff @(posedge clk) begin
		if (en[3]) begin
			cmd_s3 <= cmd_s2;
			row_s3 <= row_s2;
			x_s3   <= x_s2;
			a_s3   <= a_s2;
			a7_s3  <= gf_mul(gf_sq(a3_s2), a_s2);
		end
	end

	// stage 4: a^15, keep a^7
	always_ff @(posedge clk) begin
		if (en[4]) begin
			cmd_s4 <= cmd_s3;
			row_s4 <= row_s3;
			x_s4   <= x_s3;
			a7_s4  <= a7_s3;
			a15_s4 <= gf_mul(gf_sq(a7_s3), a_s3);
		end
	end

	// stage 5: a^254 = (a^120 * a^7)^2, zero maps to zero
	always_ff @(posedge clk) begin
		if (en[5]) begin
			cmd_s5 <= cmd_s4;
			row_s5 <= row_s4;
			x_s5   <= x_s4;
			inv_s5 <= gf_sq(gf_mul(gf_sq(gf_sq(gf_sq(a15_s4))), a7_s4));
		end
	end

	// stage 6: affine step, coefficient products and byte placement
	always_comb begin
		byte_t v;
		byte_t m2, m3, m4, m8, m9, mb, md, me;
		byte_t coef_bytes [4];
		row_t  idx;

		idx = '0;
		if (cmd_s5 == CMD_SBOX || cmd_s5 == CMD_FWD_TBL) begin
			v = aff_fwd(inv_s5);
		end else if (cmd_s5 == CMD_INV_MIX) begin
			v = x_s5;
		end else begin
			v = inv_s5;
		end

		m2 = xtime(v);
		m3 = m2 ^ v;
		m4 = xtime(m2);
		m8 = xtime(m4);
		m9 = m8 ^ v;
		mb = m8 ^ m2 ^ v;
		md = m8 ^ m4 ^ v;
		me = m8 ^ m4 ^ m2;

		if (cmd_s5 == CMD_FWD_TBL) begin
			coef_bytes[0] = m3;
			coef_bytes[1] = v;
			coef_bytes[2] = v;
			coef_bytes[3] = m2;
		end else begin
			coef_bytes[0] = mb;
			coef_bytes[1] = md;
			coef_bytes[2] = m9;
			coef_bytes[3] = me;
		end

		word_nxt = '0;
		case (cmd_s5)
			CMD_SBOX, CMD_INV_SBOX: begin
				word_nxt = {24'h000000, v} << {row_s5, 3'b000};
			end
			CMD_FWD_TBL, CMD_INV_TBL, CMD_INV_MIX: begin
				for (int k = 0; k < 4; k++) begin
					idx = row_s5 + 2'(k);
					word_nxt[31-8*k -: 8] = coef_bytes[idx];
				end
			end
			default: begin
				word_nxt = '0;
			end
		endcase
	end

	// stage 6: output register
	always_ff @(posedge clk) begin
		if (en[6]) begin
			word_s6 <= word_nxt;
		end
	end

endmodule

FILE: test/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top: testbench for the AES S-box and round table word core
// Drives lookup requests through the request channel with random gaps,
// predicts each table word from GF(2^8) tables built at time zero, and
// compares every response transfer in order against the predicted words.
// The response side stalls at random. A watchdog ends a hung run.
// ---------------------------------------------------------------------------
module tb_top import asrtw_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int   RANDOM_ITEMS   = 1800;
	localparam int   WATCHDOG_LIMIT = 2000;
	localparam int   DRAIN_CYCLES   = 24;
	localparam cmd_t CMD_LAST       = 3'd7;

	typedef struct packed {
		cmd_t  command;
		byte_t operand_byte;
		row_t  row_select;
	} lookup_req_t;

	logic clk;
	logic arst_n;

	asrtw_req_if req_ch ();
	asrtw_rsp_if rsp_ch ();

	aes_sbox_and_round_table_word_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	lookup_req_t lookup_q[$];
	word_t       table_word_q[$];
	byte_t       sub_tbl [256];
	byte_t       inv_sub_tbl [256];
	int          fail_count = 0;
	int          stall_cycles = 0;
	int          send_gap = 0;
	int          send_burst = 0;
	int          recv_gap = 0;
	int          recv_burst = 0;

	byte_t fwd_coef [4] = '{8'h03, 8'h01, 8'h01, 8'h02};
	byte_t inv_coef [4] = '{8'h0b, 8'h0d, 8'h09, 8'h0e};

	// GF(2^8) product, reduction by x^8+x^4+x^3+x+1
	function automatic byte_t gf_prod(input byte_t a, input byte_t b);
		byte_t p;
		byte_t m;
		p = 8'h00;
		m = a;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) begin
				p ^= m;
			end
			m = m[7] ? ((m << 1) ^ 8'h1b) : (m << 1);
		end
		return p;
	endfunction

	// pack four coefficient products, rotated by row, top byte first
	function automatic word_t coef_word(input byte_t coef [4], input byte_t v,
		input row_t row);
		word_t w;
		w = '0;
		for (int k = 0; k < 4; k++) begin
			w = {w[23:0], gf_prod(coef[(row + k) % 4], v)};
		end
		return w;
	endfunction

	function automatic word_t predict_table_word(input lookup_req_t r);
		case (r.command)
			CMD_SBOX:     return word_t'(sub_tbl[r.operand_byte]) << (8 * r.row_select);
			CMD_INV_SBOX: return word_t'(inv_sub_tbl[r.operand_byte]) << (8 * r.row_select);
			CMD_FWD_TBL:  return coef_word(fwd_coef, sub_tbl[r.operand_byte], r.row_select);
			CMD_INV_TBL:  return coef_word(inv_coef, inv_sub_tbl[r.operand_byte],
				r.row_select);
			CMD_INV_MIX:  return coef_word(inv_coef, r.operand_byte, r.row_select);
			default:      return '0;
		endcase
	endfunction

	// idle cycles before the next item: mostly random, sometimes a burst of none
	function automatic int draw_gap(inout int burst);
		if (burst > 0) begin
			burst--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			burst = $urandom_range(8, 40);
			return 0;
		end
		return $urandom_range(0, 15);
	endfunction

	task automatic queue_lookup(input cmd_t c, input byte_t x, input row_t r);
		lookup_req_t item;
		item.command      = c;
		item.operand_byte = x;
		item.row_select   = r;
		lookup_q.push_back(item);
	endtask

	always #1 clk = ~clk;

	// request driver: present the oldest pending item, hold it until transfer
	always @(posedge clk or negedge arst_n) begin : req_driver
		logic busy;
		if (!arst_n) begin
			req_ch.valid        <= 1'b0;
			req_ch.command      <= '0;
			req_ch.operand_byte <= '0;
			req_ch.row_select   <= '0;
		end else begin
			busy = req_ch.valid && !req_ch.ready;
			if (req_ch.valid && req_ch.ready) begin
				table_word_q.push_back(predict_table_word(lookup_q[0]));
				lookup_q.pop_front();
				send_gap = draw_gap(send_burst);
			end
			if (!busy) begin
				if (send_gap > 0 || lookup_q.size() == 0) begin
					if (send_gap > 0) begin
						send_gap--;
					end
					req_ch.valid <= 1'b0;
				end else begin
					req_ch.valid        <= 1'b1;
					req_ch.command      <= lookup_q[0].command;
					req_ch.operand_byte <= lookup_q[0].operand_byte;
					req_ch.row_select   <= lookup_q[0].row_select;
				end
			end
		end
	end

	// response monitor: compare each transfer with the oldest predicted word
	always @(posedge clk or negedge arst_n) begin : rsp_monitor
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (table_word_q.size() == 0) begin
					$error("unexpected response, table_word actual %08h",
						rsp_ch.table_word);
					fail_count++;
				end else begin
					if (rsp_ch.table_word !== table_word_q[0]) begin
						$error("table_word mismatch: expected %08h actual %08h",
							table_word_q[0], rsp_ch.table_word);
						fail_count++;
					end
					table_word_q.pop_front();
				end
				recv_gap = draw_gap(recv_burst);
			end
			if (recv_gap > 0) begin
				recv_gap--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// watchdog: count cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin : main_seq
		byte_t inv;
		byte_t s;
		int    pick;
		clk                 = 1'b0;
		arst_n              = 1'b0;
		req_ch.valid        = 1'b0;
		req_ch.command      = '0;
		req_ch.operand_byte = '0;
		req_ch.row_select   = '0;
		rsp_ch.ready        = 1'b0;

		// build S-box and its inverse: inverse as x^254, then the affine step
		for (int x = 0; x < 256; x++) begin
			inv = 8'h01;
			repeat (254) inv = gf_prod(inv, byte_t'(x));
			for (int i = 0; i < 8; i++) begin
				s[i] = inv[i] ^ inv[(i + 4) % 8] ^ inv[(i + 5) % 8]
					^ inv[(i + 6) % 8] ^ inv[(i + 7) % 8] ^ AFF_FWD_C[i];
			end
			sub_tbl[x]     = s;
			inv_sub_tbl[s] = byte_t'(x);
		end

		// directed: zero and all-ones bytes for every code, on rows set from the code
		for (int c = 0; c <= CMD_LAST; c++) begin
			queue_lookup(cmd_t'(c), 8'h00, row_t'(c));
			queue_lookup(cmd_t'(c), 8'hff, row_t'(c + 2));
		end
		queue_lookup(CMD_FWD_TBL, 8'h80, 2'd1);
		queue_lookup(CMD_INV_TBL, 8'h01, 2'd2);
		queue_lookup(CMD_INV_MIX, 8'h53, 2'd3);
		queue_lookup(CMD_INV_SBOX, 8'h63, 2'd0);

		// random: mostly defined commands, a few unused codes
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			pick = $urandom_range(0, 19);
			queue_lookup(pick < 2 ? cmd_t'($urandom_range(CMD_INV_MIX + 1, CMD_LAST))
				: cmd_t'(pick % 5), byte_t'($urandom_range(0, 255)),
				row_t'($urandom_range(0, 3)));
		end

		// reset, released away from the rising edge
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// drain, then allow for any stray response
		while (lookup_q.size() != 0 || table_word_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
